[sv/dsu_pkg.sv]
`timescale 1ns / 1ps

package dsu_pkg;

    localparam int IDX_W       = 10;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNION = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

    typedef enum logic [1:0] {
        RD_IN   = 2'd0,
        RD_B    = 2'd1,
        RD_DATA = 2'd2
    } t_rd_src;

    typedef enum logic [1:0] {
        WR_CLEAR = 2'd0,
        WR_HALVE = 2'd1,
        WR_LINK  = 2'd2,
        WR_SUM   = 2'd3
    } t_wr_src;

    typedef enum logic [1:0] {
        RES_FAIL    = 2'd0,
        RES_OK_ZERO = 2'd1,
        RES_CUR     = 2'd2,
        RES_PE      = 2'd3
    } t_res_src;

    typedef struct packed {
        logic     latch;
        logic     rd_en;
        t_rd_src  rd_src;
        logic     wr_en;
        t_wr_src  wr_src;
        logic     cnt_inc;
        logic     va_load;
        logic     pe_load;
        logic     cur_adv;
        logic     res_set;
        t_res_src res_src;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic a_ok;
        logic neg;
        logic union_ok;
        logic cnt_last;
    } t_dp_sts;

endpackage

[sv/dsu_datapath.sv]
`timescale 1ns / 1ps

module dsu_datapath #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dsu_pkg::IDX_W-1:0]  i_a,
    input  logic [dsu_pkg::IDX_W-1:0]  i_b,
    input  dsu_pkg::t_dp_cmd           i_cmd,
    output dsu_pkg::t_dp_sts           o_sts,
    output logic [dsu_pkg::IDX_W-1:0]  o_root,
    output logic                       o_done_ok
);

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int EW = AW + 1;

    logic signed [EW-1:0] r_mem [NUM_ELEMENTS];
    logic signed [EW-1:0] r_rd_data;
    logic signed [EW-1:0] r_va;
    logic [AW-1:0]        r_cur;
    logic [AW-1:0]        r_pe;
    logic [AW-1:0]        r_b;
    logic                 r_a_ok;
    logic                 r_b_ok;
    logic [AW-1:0]        r_cnt;
    logic [AW-1:0]        n_cnt;
    logic [dsu_pkg::IDX_W-1:0] r_res_root;
    logic                 r_res_ok;
    logic [dsu_pkg::IDX_W-1:0] r_out_root;
    logic                 r_out_ok;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic signed [EW-1:0] wr_data;
    logic signed [EW-1:0] sum;
    logic                 a_wins;

    assign sum    = r_va + r_rd_data;
    assign a_wins = r_va < r_rd_data;

    always_comb begin
        case (i_cmd.rd_src)
            dsu_pkg::RD_IN:   rd_addr = AW'(i_a);
            dsu_pkg::RD_B:    rd_addr = r_b;
            dsu_pkg::RD_DATA: rd_addr = r_rd_data[AW-1:0];
            default:          rd_addr = r_rd_data[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.wr_src)
            dsu_pkg::WR_CLEAR: begin
                wr_addr = r_cnt;
                wr_data = '1;
            end
            dsu_pkg::WR_HALVE: begin
                wr_addr = r_cur;
                wr_data = r_rd_data;
            end
            dsu_pkg::WR_LINK: begin
                wr_addr = a_wins ? r_b : r_cur;
                wr_data = $signed({1'b0, (a_wins ? r_cur : r_b)});
            end
            dsu_pkg::WR_SUM: begin
                wr_addr = a_wins ? r_cur : r_b;
                wr_data = sum;
            end
            default: begin
                wr_addr = r_cnt;
                wr_data = '1;
            end
        endcase
    end

    // parent table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign n_cnt = (r_cnt == AW'(NUM_ELEMENTS - 1)) ? '0 : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cur  <= AW'(i_a);
            r_b    <= AW'(i_b);
            r_a_ok <= 32'(i_a) < NUM_ELEMENTS;
            r_b_ok <= 32'(i_b) < NUM_ELEMENTS;
        end else if (i_cmd.cur_adv) begin
            r_cur <= r_pe;
        end
        if (i_cmd.pe_load) begin
            r_pe <= r_rd_data[AW-1:0];
        end
        if (i_cmd.va_load) begin
            r_va <= r_rd_data;
        end
        if (i_cmd.res_set) begin
            case (i_cmd.res_src)
                dsu_pkg::RES_FAIL: begin
                    r_res_root <= '0;
                    r_res_ok   <= 1'b0;
                end
                dsu_pkg::RES_OK_ZERO: begin
                    r_res_root <= '0;
                    r_res_ok   <= 1'b1;
                end
                dsu_pkg::RES_CUR: begin
                    r_res_root <= dsu_pkg::IDX_W'(r_cur);
                    r_res_ok   <= 1'b1;
                end
                dsu_pkg::RES_PE: begin
                    r_res_root <= dsu_pkg::IDX_W'(r_pe);
                    r_res_ok   <= 1'b1;
                end
                default: begin
                    r_res_root <= '0;
                    r_res_ok   <= 1'b0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_root <= r_res_root;
            r_out_ok   <= r_res_ok;
        end
    end

    assign o_sts.a_ok     = r_a_ok;
    assign o_sts.neg      = r_rd_data[EW-1];
    assign o_sts.union_ok = r_a_ok && r_b_ok && (r_cur != r_b)
                            && r_va[EW-1] && r_rd_data[EW-1];
    assign o_sts.cnt_last = (r_cnt == AW'(NUM_ELEMENTS - 1));

    assign o_root    = r_out_root;
    assign o_done_ok = r_out_ok;

`ifndef SYNTHESIS
    // a halving write never lands on the entry read in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.rd_en) |-> (wr_addr != rd_addr))
        else $error("parent write collides with read address");

    // a new root always stores a negative size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wr_src == dsu_pkg::WR_SUM) |-> wr_data[EW-1])
        else $error("root size written non-negative");
`endif

endmodule

[sv/dsu_ctrl.sv]
`timescale 1ns / 1ps

module dsu_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic [dsu_pkg::MODE_W-1:0]  i_mode,
    output logic                        o_s_ready,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output dsu_pkg::t_dp_cmd            o_cmd,
    input  dsu_pkg::t_dp_sts            i_sts
);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_FIND1 = 9'b000000100,
        S_WALK  = 9'b000001000,
        S_URB   = 9'b000010000,
        S_UCHK  = 9'b000100000,
        S_UW2   = 9'b001000000,
        S_CLEAR = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = dsu_pkg::WR_CLEAR;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_mode)
                        dsu_pkg::MODE_FIND: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_src = dsu_pkg::RD_IN;
                            n_state      = S_FIND1;
                        end
                        dsu_pkg::MODE_UNION: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_src = dsu_pkg::RD_IN;
                            n_state      = S_URB;
                        end
                        dsu_pkg::MODE_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_src = dsu_pkg::RES_FAIL;
                            n_state       = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND1: begin
                if (!i_sts.a_ok) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_src = dsu_pkg::RES_FAIL;
                    n_state       = S_DONE;
                end else if (i_sts.neg) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_src = dsu_pkg::RES_CUR;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.pe_load = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = dsu_pkg::RD_DATA;
                    n_state       = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.neg) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_src = dsu_pkg::RES_PE;
                    n_state       = S_DONE;
                end else begin
                    // point current node at its grandparent, step to parent
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_src  = dsu_pkg::WR_HALVE;
                    o_cmd.cur_adv = 1'b1;
                    o_cmd.pe_load = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = dsu_pkg::RD_DATA;
                end
            end
            S_URB: begin
                o_cmd.va_load = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_src  = dsu_pkg::RD_B;
                n_state       = S_UCHK;
            end
            S_UCHK: begin
                if (!i_sts.union_ok) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_src = dsu_pkg::RES_FAIL;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = dsu_pkg::WR_LINK;
                    n_state      = S_UW2;
                end
            end
            S_UW2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = dsu_pkg::WR_SUM;
                o_cmd.res_set = 1'b1;
                o_cmd.res_src = dsu_pkg::RES_OK_ZERO;
                n_state       = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = dsu_pkg::WR_CLEAR;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_src = dsu_pkg::RES_OK_ZERO;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;

`ifndef SYNTHESIS
    // result register is only loaded when its slot is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_m_ready))
        else $error("result overwritten before taken");

    // a clear request starts the sweep right away
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready && i_mode == dsu_pkg::MODE_CLEAR) |=> (r_state == S_CLEAR))
        else $error("clear request did not start sweep");

    // table is never written while idle or while a result waits to be taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !o_cmd.wr_en)
        else $error("table written outside an operation");
`endif

endmodule

[sv/disjoint_set_union_find_top.sv]
`timescale 1ns / 1ps

// channel   | direction | tdata                          | tuser
// s_axis    | in        | [9:0] element_a, [19:10] elem_b | [1:0] mode
// m_axis    | out       | [9:0] root                     | [0] done_ok
//
// one request at a time; find walks to the root with one parent
// table read per hop through the single read port (hops <= log2 of set size)
// union links two distinct in-range roots, else it is refused; clear sweeps the table to -1
// after reset the table is swept to -1 while s_axis_tready is low
// a waiting result on m_axis does not block acceptance of the next request

module disjoint_set_union_find_top #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dsu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // element_a, element_b, pad
    input  logic [dsu_pkg::MODE_W-1:0]       s_axis_tuser,   // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dsu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // root, pad
    output logic [0:0]                       m_axis_tuser    // done_ok
);

    dsu_pkg::t_dp_cmd          cmd;
    dsu_pkg::t_dp_sts          sts;
    logic [dsu_pkg::IDX_W-1:0] root;
    logic                      done_ok;

    dsu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_mode    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    dsu_datapath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_a       (s_axis_tdata[dsu_pkg::IDX_W-1:0]),
        .i_b       (s_axis_tdata[2*dsu_pkg::IDX_W-1:dsu_pkg::IDX_W]),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_root    (root),
        .o_done_ok (done_ok)
    );

    assign m_axis_tdata = {{(dsu_pkg::OUT_TDATA_W - dsu_pkg::IDX_W){1'b0}}, root};
    assign m_axis_tuser = done_ok;

endmodule
